// ===== hw/rtl/ssil_pkg.sv =====
`default_nettype none

package ssil_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int POS_W            = 7;
    localparam int IN_USER_W        = 1;
    localparam int OUT_DATA_W       = 24;
    localparam int OUT_PAD_W        = OUT_DATA_W - 3 - 2 * POS_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the incoming transaction, open the search window
        logic srch_rd;   // read the middle entry of the window
        logic srch_cmp;  // narrow the window with the entry just read
        logic decide;    // settle insert or reject, arm the shift index
        logic sh_rd;     // read the entry below the shift index
        logic sh_wr;     // move it up one place
        logic ins_wr;    // store the new value, bump the count
        logic res_load;  // load the output register
    } ssil_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic ins_pend;
        logic shift_done;
        logic out_free;
    } ssil_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssil_ctrl.sv =====
`default_nettype none

module ssil_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire ssil_pkg::ssil_stat_t stat,
    output logic                     in_ready,
    output ssil_pkg::ssil_cmd_t      cmd
);
    import ssil_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SRCH   = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_SH_CHK = 3'd4;
    localparam logic [2:0] ST_SH_WR  = 3'd5;
    localparam logic [2:0] ST_INS_WR = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (stat.search_done)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_SRCH;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_SH_CHK;
            end
            ST_SH_CHK:
            begin
                if (!stat.ins_pend)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.shift_done)
                begin
                    state_next = ST_INS_WR;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_SH_CHK;
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssil_dpath.sv =====
`default_nettype none

module ssil_dpath
#(
    parameter int CAPACITY = ssil_pkg::DEFAULT_CAPACITY
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ssil_pkg::ssil_cmd_t              cmd,
    input  wire logic                             in_op,
    input  wire logic [ssil_pkg::VALUE_W-1:0]     in_value,
    input  wire logic                             out_ready,
    output ssil_pkg::ssil_stat_t                  stat,
    output logic                                  out_valid,
    output logic [ssil_pkg::OUT_DATA_W-1:0]       out_data
);
    import ssil_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // sorted store, ascending, entries at and above the count are don't-care
    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic                      op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          lo_reg;
    logic [CNT_W-1:0]          hi_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      found_reg;
    logic                      ins_reg;
    logic                      rej_reg;
    logic signed [VALUE_W-1:0] rdata_reg;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    logic [CNT_W:0]            mid_sum;
    logic [CNT_W-1:0]          mid;
    logic [CNT_W-1:0]          idx_m1;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic                      wr_en;
    logic                      new_value;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CNT_W:1];
    assign idx_m1    = idx_reg - 1'b1;
    assign new_value = (op_reg == OP_INSERT) && !found_reg;

    assign rd_en   = cmd.srch_rd | cmd.sh_rd;
    assign rd_addr = cmd.sh_rd ? idx_m1[IDX_W-1:0] : mid[IDX_W-1:0];
    assign wr_en   = cmd.sh_wr | cmd.ins_wr;
    assign wr_addr = cmd.sh_wr ? idx_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
    assign wr_data = cmd.sh_wr ? rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // search window, item, decision and shift index registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            value_reg <= $signed(in_value);
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            found_reg <= 1'b0;
        end
        else if (cmd.srch_cmp)
        begin
            if (rdata_reg < value_reg)
            begin
                lo_reg <= mid + 1'b1;
            end
            else if (rdata_reg == value_reg)
            begin
                // hit: lo doubles as the reported position
                lo_reg    <= mid;
                found_reg <= 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.decide)
        begin
            ins_reg <= new_value && (count_reg != CAP_CNT);
            rej_reg <= new_value && (count_reg == CAP_CNT);
            idx_reg <= count_reg;
        end
        else if (cmd.sh_wr)
        begin
            idx_reg <= idx_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, POS_W'(count_reg), POS_W'(lo_reg),
                             rej_reg, ins_reg, found_reg};
        end
    end

    assign stat.search_done = found_reg || (lo_reg == hi_reg);
    assign stat.ins_pend    = ins_reg;
    assign stat.shift_done  = (idx_reg == lo_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_set_insert_lookup.sv =====
`default_nettype none

// channel   dir   signals                      content
// s_axis    in    tvalid tready tdata tuser    one insert or query transaction
// m_axis    out   tvalid tready tdata          one result transaction per input
//
// one transaction at a time: accept, then per binary search step a registered
// memory read and then a compare, then search exit and decide, then on an insert
// a shift check, registered read and write per entry moved up (count - position)
// and one write of the new value, then result handoff. reset clears the state,
// the count and the output valid only; the store needs no clearing, since only
// entries below the count are read.
// a stalled result sits in the output register while the next search runs up
// to its handoff.

module sorted_set_insert_lookup
#(
    parameter int CAPACITY = ssil_pkg::DEFAULT_CAPACITY
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] item_value (signed)
    input  wire logic [ssil_pkg::VALUE_W-1:0]       s_axis_tdata,
    // [0] opcode: 0 insert, 1 query
    input  wire logic [ssil_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] present, [1] inserted, [2] full_reject, [9:3] position,
    // [16:10] entry_count, [23:17] zero
    output logic [ssil_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import ssil_pkg::*;

    ssil_cmd_t  cmd;
    ssil_stat_t stat;
    logic       in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // state machine: sequences search, shift and result handoff
    ssil_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // sorted store, search window, shift index and output register
    ssil_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (s_axis_tuser[0]),
        .in_value  (s_axis_tdata),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY     = ssil_pkg::DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_LEN   = 200;    // longest insert shift plus search and handoff
    localparam int PHASE_ITEMS  = 100;

    typedef logic signed [ssil_pkg::VALUE_W-1:0] value_t;

    // same bit order as m_axis_tdata[16:0]
    typedef struct packed {
        logic [ssil_pkg::POS_W-1:0] entry_count;
        logic [ssil_pkg::POS_W-1:0] position;
        logic                       full_reject;
        logic                       inserted;
        logic                       present;
    } set_result_t;

    // mirror of the set contents plus the results still owed by the block
    class set_scoreboard;
        value_t      held[$];              // ascending, distinct
        set_result_t pending_results[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // search the mirror, apply the transaction, queue the result it must give
        function void apply_item(logic op, value_t v);
            set_result_t r;
            int          pos;
            bit          found;
            pos   = 0;
            found = 1'b0;
            foreach (held[i])
            begin
                if (held[i] < v)
                    pos++;
                else if (held[i] == v)
                    found = 1'b1;
            end
            r = '0;
            r.present = found;
            if (op == ssil_pkg::OP_INSERT && !found)
            begin
                // a full set refuses a new value but still reports its slot
                if (held.size() >= CAPACITY)
                    r.full_reject = 1'b1;
                else
                begin
                    held.insert(pos, v);
                    r.inserted = 1'b1;
                end
            end
            r.position    = ssil_pkg::POS_W'(pos);
            r.entry_count = ssil_pkg::POS_W'(held.size());
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [ssil_pkg::POS_W-1:0] want,
                                    logic [ssil_pkg::POS_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [ssil_pkg::OUT_DATA_W-1:0] d);
            set_result_t want;
            set_result_t got;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with none outstanding: %h", d);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            got  = set_result_t'(d[16:0]);
            compare_field("present", want.present, got.present);
            compare_field("inserted", want.inserted, got.inserted);
            compare_field("full_reject", want.full_reject, got.full_reject);
            compare_field("position", want.position, got.position);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("pad", '0, d[ssil_pkg::OUT_DATA_W-1:17]);
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [ssil_pkg::VALUE_W-1:0]       s_axis_tdata;
    logic [ssil_pkg::IN_USER_W-1:0]     s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [ssil_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

    set_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycles;

    sorted_set_insert_lookup #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver backpressure, rate set per phase
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // both handshakes seen at the same edge, inputs first
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.apply_item(s_axis_tuser[0], value_t'(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // present one transaction, optionally after random gaps, hold until accepted
    task automatic send_item(logic op, value_t v);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // the last transaction is noted at the edge that accepted it, so look from the next one
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
    endtask

    // mix of fresh values, held values, their neighbors, extremes and small values
    function automatic value_t pick_value();
        int unsigned roll;
        int          idx;
        int          near_zero;
        value_t      v;
        roll = $urandom_range(0, 99);
        if (roll < 35 || sb.held.size() == 0)
            v = value_t'($urandom);
        else if (roll < 80)
        begin
            idx = $urandom_range(0, sb.held.size() - 1);
            v   = sb.held[idx];
            if (roll >= 65)
                v = $urandom_range(0, 1) ? v + 1 : v - 1;
        end
        else if (roll < 90)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7fff_ffff;
                2: v = 32'sh8000_0001;
                default: v = 32'sh7fff_fffe;
            endcase
        end
        else
        begin
            near_zero = $urandom_range(0, 16);
            v = near_zero - 8;
        end
        return v;
    endfunction

    initial
    begin
        int   phase;
        logic op;
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set: queries and the first insert land at slot 0
        send_item(ssil_pkg::OP_QUERY, 32'sd0);
        send_item(ssil_pkg::OP_QUERY, 32'sh8000_0000);
        send_item(ssil_pkg::OP_INSERT, 32'sd0);
        // duplicate insert leaves the set alone
        send_item(ssil_pkg::OP_INSERT, 32'sd0);
        // append at the top, then push to the bottom so everything shifts
        send_item(ssil_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_item(ssil_pkg::OP_INSERT, 32'sh8000_0000);
        send_item(ssil_pkg::OP_INSERT, -32'sd1);
        send_item(ssil_pkg::OP_INSERT, 32'sd1);
        // hits at both ends, misses just inside them
        send_item(ssil_pkg::OP_QUERY, 32'sh7fff_ffff);
        send_item(ssil_pkg::OP_QUERY, 32'sh8000_0000);
        send_item(ssil_pkg::OP_QUERY, 32'sh7fff_fffe);
        send_item(ssil_pkg::OP_QUERY, 32'sh8000_0001);
        send_item(ssil_pkg::OP_INSERT, -32'sd1);
        // alternating bit patterns, absent then present
        send_item(ssil_pkg::OP_QUERY, 32'sh5555_5555);
        send_item(ssil_pkg::OP_QUERY, 32'shaaaa_aaaa);
        send_item(ssil_pkg::OP_INSERT, 32'sh5555_5555);
        send_item(ssil_pkg::OP_INSERT, 32'shaaaa_aaaa);
        send_item(ssil_pkg::OP_QUERY, 32'sh5555_5555);
        send_item(ssil_pkg::OP_QUERY, 32'shaaaa_aaaa);
        send_item(ssil_pkg::OP_QUERY, 32'sd0);

        // hold off the sender until the block has answered everything
        drain_results();

        // random traffic, the set fills and then rejects new values
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (PHASE_ITEMS)
            begin
                op = ($urandom_range(0, 99) < 65) ? ssil_pkg::OP_INSERT : ssil_pkg::OP_QUERY;
                send_item(op, pick_value());
            end
            drain_results();
        end

        // catch any stray result after the last one
        repeat (SETTLE_LEN) @(posedge clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
